### sv/cts_pkg.sv
// shared types and constants of the cooperative task scheduler
package cts_pkg;

  localparam int HANDLE_W    = 8;
  localparam int DELAY_W     = 16;
  localparam int COUNTDOWN_W = 17;
  localparam int SLOT_W      = 3;
  localparam int MAX_RESULTS = 8;
  localparam int REP_CNT_W   = 4;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  // status codes of a result item
  typedef enum logic [1:0] {
    RSP_OK    = 2'd0,
    RSP_FULL  = 2'd1,
    RSP_EMPTY = 2'd2
  } rsp_status_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_REMOVE,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]          operation;
    logic [HANDLE_W-1:0] task_handle;
    logic [DELAY_W-1:0]  start_delay;
    logic [DELAY_W-1:0]  repeat_period;
    logic [SLOT_W-1:0]   target_slot;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SLOT_W-1:0]   slot_index;
    logic [HANDLE_W-1:0] due_handle;
    logic                due_valid;
    logic                was_removed;
    logic                last;
  } rsp_t;

  // one entry of the slot memory
  typedef struct packed {
    logic [HANDLE_W-1:0]    handle;
    logic [COUNTDOWN_W-1:0] countdown;
    logic [DELAY_W-1:0]     period;
  } slot_entry_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic ptr_inc;
    logic rd_en;
    logic add_commit;
    logic rem_commit;
    logic eval_commit;
    logic fin_commit;
  } dp_ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic ptr_end;
    logic ptr_slot_valid;
    logic eval_blocked;
    logic out_free;
  } dp_status_t;

endpackage

### sv/cts_if.sv
// command and response channel interfaces of the scheduler
interface cts_cmd_if import cts_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cts_rsp_if import cts_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/cts_ctrl.sv
// controller state machine of the scheduler
module cts_ctrl import cts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  logic [1:0] op_i,
  output logic       cmd_ready_o,
  input  dp_status_t stat_i,
  output dp_ctrl_t   ctrl_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (op_i)
            OP_ADD:    state_d = ST_ADD;
            OP_REMOVE: state_d = ST_REMOVE;
            OP_TICK:   state_d = ST_READ;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD, ST_REMOVE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      ST_READ: begin
        if (stat_i.ptr_end) begin
          state_d = ST_FINISH;
        end else if (stat_i.ptr_slot_valid) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!stat_i.eval_blocked) state_d = ST_READ;
      end
      ST_FINISH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_ready_o = 1'b0;
    ctrl_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o    = 1'b1;
        ctrl_o.capture = cmd_valid_i;
      end
      ST_ADD:    ctrl_o.add_commit = stat_i.out_free;
      ST_REMOVE: ctrl_o.rem_commit = stat_i.out_free;
      ST_READ: begin
        if (!stat_i.ptr_end) begin
          ctrl_o.rd_en   = stat_i.ptr_slot_valid;
          ctrl_o.ptr_inc = !stat_i.ptr_slot_valid;
        end
      end
      ST_EVAL:   ctrl_o.eval_commit = !stat_i.eval_blocked;
      ST_FINISH: ctrl_o.fin_commit  = stat_i.out_free;
      default: begin
        cmd_ready_o = 1'b0;
      end
    endcase
  end

  // a slot is evaluated only right after its read
  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> ($past(state_q) == ST_READ || $past(state_q) == ST_EVAL))
    else $error("evaluation entered without a slot read");

endmodule

### sv/cts_dpath.sv
// datapath of the scheduler: slot table, scan pointer, result registers
module cts_dpath import cts_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_data_i,
  input  logic       rsp_ready_i,
  output logic       rsp_valid_o,
  output rsp_t       rsp_data_o,
  input  dp_ctrl_t   ctrl_i,
  output dp_status_t stat_o
);

  localparam int IDXW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PTRW = $clog2(SLOT_COUNT + 1);

  cmd_t                   cmd_q;
  logic [PTRW-1:0]        ptr_q;
  logic [IDXW-1:0]        ptr_idx;
  logic [SLOT_COUNT-1:0]  slot_valid_q, slot_valid_d;
  slot_entry_t            mem_q [SLOT_COUNT];
  slot_entry_t            rd_q;
  logic                   mem_we;
  logic [IDXW-1:0]        mem_waddr;
  slot_entry_t            mem_wdata;
  logic [SLOT_COUNT-1:0]  free_oh;
  logic                   table_full;
  logic [IDXW-1:0]        add_idx;
  logic [IDXW+2:0]        add_ext, ptr_ext, tgt_ext;
  logic [IDXW-1:0]        tgt_idx;
  logic                   rem_hit;
  logic [COUNTDOWN_W-1:0] cnt_dec;
  logic                   due, one_shot, report;
  rsp_t                   due_rsp;
  logic                   pend_valid_q, pend_valid_d;
  rsp_t                   pend_q, pend_d;
  logic [REP_CNT_W-1:0]   rep_cnt_q, rep_cnt_d;
  logic                   push;
  rsp_t                   push_data;
  logic                   rsp_valid_q, rsp_valid_d;
  rsp_t                   rsp_q;
  logic                   out_free;

  // captured input item
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) cmd_q <= cmd_data_i;
  end

  // scan pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (ctrl_i.capture) begin
      ptr_q <= '0;
    end else if (ctrl_i.ptr_inc || ctrl_i.eval_commit) begin
      ptr_q <= ptr_q + PTRW'(1);
    end
  end

  assign ptr_idx = ptr_q[IDXW-1:0];
  assign ptr_ext = {3'b000, ptr_idx};

  // lowest free slot
  assign free_oh    = ~slot_valid_q & (slot_valid_q + SLOT_COUNT'(1));
  assign table_full = &slot_valid_q;

  always_comb begin
    add_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (free_oh[i]) add_idx = add_idx | IDXW'(i);
    end
  end

  assign add_ext = {3'b000, add_idx};

  // remove target
  assign tgt_ext = {{IDXW{1'b0}}, cmd_q.target_slot};
  assign tgt_idx = tgt_ext[IDXW-1:0];
  assign rem_hit = (int'(cmd_q.target_slot) < SLOT_COUNT) && slot_valid_q[tgt_idx];

  // countdown evaluation of the slot just read
  assign cnt_dec  = rd_q.countdown - COUNTDOWN_W'(1);
  assign due      = (cnt_dec == '0);
  assign one_shot = (rd_q.period == '0);
  assign report   = due && (rep_cnt_q < REP_CNT_W'(MAX_RESULTS));

  always_comb begin
    due_rsp             = '0;
    due_rsp.status      = RSP_OK;
    due_rsp.slot_index  = ptr_ext[2:0];
    due_rsp.due_handle  = rd_q.handle;
    due_rsp.due_valid   = 1'b1;
    due_rsp.was_removed = one_shot;
  end

  // valid bits
  always_comb begin
    slot_valid_d = slot_valid_q;
    if (ctrl_i.add_commit && !table_full) slot_valid_d[add_idx] = 1'b1;
    if (ctrl_i.rem_commit && rem_hit) slot_valid_d[tgt_idx] = 1'b0;
    if (ctrl_i.eval_commit && due && one_shot) slot_valid_d[ptr_idx] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else begin
      slot_valid_q <= slot_valid_d;
    end
  end

  // slot memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_idx;
    mem_wdata = rd_q;
    if (ctrl_i.add_commit && !table_full) begin
      mem_we              = 1'b1;
      mem_waddr           = add_idx;
      mem_wdata.handle    = cmd_q.task_handle;
      mem_wdata.countdown = {1'b0, cmd_q.start_delay} + COUNTDOWN_W'(1);
      mem_wdata.period    = cmd_q.repeat_period;
    end else if (ctrl_i.eval_commit && !(due && one_shot)) begin
      mem_we              = 1'b1;
      mem_wdata.countdown = due ? {1'b0, rd_q.period} : cnt_dec;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (ctrl_i.rd_en) rd_q <= mem_q[ptr_idx];
  end

  // result push into the output register
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (ctrl_i.add_commit) begin
      push                 = 1'b1;
      push_data.status     = table_full ? RSP_FULL : RSP_OK;
      push_data.slot_index = table_full ? '0 : add_ext[2:0];
      push_data.last       = 1'b1;
    end else if (ctrl_i.rem_commit) begin
      push                 = 1'b1;
      push_data.status     = rem_hit ? RSP_OK : RSP_EMPTY;
      push_data.slot_index = cmd_q.target_slot;
      push_data.last       = 1'b1;
    end else if (ctrl_i.eval_commit && report && pend_valid_q) begin
      push      = 1'b1;
      push_data = pend_q;
    end else if (ctrl_i.fin_commit) begin
      push           = 1'b1;
      push_data      = pend_valid_q ? pend_q : '0;
      push_data.last = 1'b1;
    end
  end

  // held due result, released once the next one or the end of scan is known
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    rep_cnt_d    = rep_cnt_q;
    if (ctrl_i.capture) begin
      pend_valid_d = 1'b0;
      rep_cnt_d    = '0;
    end else if (ctrl_i.eval_commit && report) begin
      pend_valid_d = 1'b1;
      pend_d       = due_rsp;
      rep_cnt_d    = rep_cnt_q + REP_CNT_W'(1);
    end else if (ctrl_i.fin_commit) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      rep_cnt_q    <= '0;
    end else begin
      pend_valid_q <= pend_valid_d;
      rep_cnt_q    <= rep_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  // output register
  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (push) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) rsp_q <= push_data;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_data_o  = rsp_q;

  // status to the controller
  assign stat_o.ptr_end        = (ptr_q == PTRW'(SLOT_COUNT));
  assign stat_o.ptr_slot_valid = !stat_o.ptr_end && slot_valid_q[ptr_idx];
  assign stat_o.eval_blocked   = report && pend_valid_q && !out_free;
  assign stat_o.out_free       = out_free;

  // a pending result is never overwritten before its transfer
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("output register overwritten before transfer");

  // reported results per tick stay within the limit
  a_rep_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_cnt_q <= REP_CNT_W'(MAX_RESULTS))
    else $error("too many due results in one tick");

  // only occupied slots are read from memory
  a_read_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.rd_en |-> (!stat_o.ptr_end && slot_valid_q[ptr_idx]))
    else $error("memory read of a free slot");

endmodule

### sv/cooperative_task_scheduler_core.sv
// cooperative task scheduler: top level joining controller and datapath
//
// Usage: items arrive on cmd_i (valid/ready); a transfer takes place when
// both are high. Operation add places a task into the lowest free slot,
// remove frees one slot, tick ages every occupied slot and reports the due
// tasks in slot order. Results leave on rsp_o (valid/ready); each item gives
// one result, a tick one result per due task (at most eight) or one empty
// result, and the final result of an item carries last.
// Sequencing: one item is worked on at a time. Add and remove load their result
// into the output register from their own state and then return to idle. A
// tick walks the slot table in slot order, skipping free slots; each occupied
// slot is first read from memory and then evaluated and written back. After
// the last slot the final result is loaded, and the next item can be taken
// even while that result still waits in the output register.
// Reset empties the table and drops any result not yet transferred.
// A stalled receiver holds the result in the output register; a tick keeps one
// due result back and pauses at the following due task, and add, remove and
// the end of a tick wait, until that register is free again.
module cooperative_task_scheduler_core import cts_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cts_cmd_if.sink     cmd_i,
  cts_rsp_if.source   rsp_o
);

  dp_ctrl_t   ctrl;
  dp_status_t stat;

  // sequencing of each item
  cts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .op_i        (cmd_i.data.operation),
    .cmd_ready_o (cmd_i.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // slot table and result path
  cts_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_data_i  (cmd_i.data),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_data_o  (rsp_o.data),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule
